// ----- hdl/generational_handle_table_assert.svh -----
// Assertion macros for the generational handle table.
// Used by the top level only.
`ifndef GENERATIONAL_HANDLE_TABLE_ASSERT_SVH
`define GENERATIONAL_HANDLE_TABLE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define GHT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define GHT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- hdl/ght_pkg.sv -----
// Package for the generational handle table: sizes, codes, payload structs.
// No dependencies.
package ght_pkg;
  localparam int Slots = 256;
  localparam int IdxW = $clog2(Slots);
  localparam int CntW = $clog2(Slots + 1);

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_LOOKUP = 3'd2;
  localparam logic [2:0] OP_LOOKUP_OWN = 3'd3;
  localparam logic [2:0] OP_FIND = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [2:0] opcode;
    logic [15:0] object_id;
    logic [13:0] owner_id;
    logic [29:0] handle;
  } ght_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [29:0] handle_out;
    logic [15:0] object_out;
    logic [15:0] live_entries;
  } ght_out_t;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EXEC, S_SCAN, S_HWM, S_DONE
  } ght_state_t;

  typedef struct packed {
    logic load;
    logic read;
    logic exec;
    logic scan;
    logic hwm;
    logic out_load;
  } ght_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_done;
    logic need_hwm;
    logic hwm_done;
  } ght_stat_t;
endpackage

// ----- hdl/ght_datapath.sv -----
// Datapath: slot memories, live bits, counters, scan and high-water search.
// Depends on ght_pkg.
module ght_datapath (
  input  logic clk,
  input  logic rst_n,
  input  ght_pkg::ght_in_t in_data,
  input  ght_pkg::ght_cmd_t cmd,
  output ght_pkg::ght_stat_t stat,
  output ght_pkg::ght_out_t result
);
  import ght_pkg::*;

  logic [13:0] mem_inst [Slots];
  logic [13:0] mem_own [Slots];
  logic [15:0] mem_obj [Slots];
  logic [Slots-1:0] live_r;
  logic [CntW-1:0] hw_r;
  logic [13:0] next_inst_r;
  logic [15:0] count_r;
  ght_in_t req_r;
  logic [13:0] rd_inst_r, rd_own_r;
  logic [15:0] rd_obj_r;
  logic [IdxW-1:0] scan_r;
  logic scan_done_r, need_hwm_r, hwm_done_r;
  logic [1:0] st_r;
  logic [29:0] hout_r;
  logic [15:0] oout_r;
  logic [IdxW-1:0] free_idx;
  logic free_found;
  logic [CntW-1:0] top_nxt;
  ght_out_t result_r;

  wire [14:0] h_idx = req_r.handle[14:0];
  wire [13:0] h_inst = req_r.handle[29:16];
  wire [IdxW-1:0] idx = h_idx[IdxW-1:0];
  wire idx_ok = ({1'b0, h_idx} < 16'(hw_r)) && (32'(h_idx) < Slots);
  wire hv = idx_ok && live_r[idx] && (rd_inst_r == h_inst);
  wire [13:0] inst_use = (next_inst_r == 14'd0) ? 14'd1 : next_inst_r;

  always_comb begin
    free_found = 1'b0;
    free_idx = '0;
    for (int i = Slots - 1; i >= 0; i--) begin
      if (!live_r[i] && (CntW'(i) < hw_r)) begin
        free_found = 1'b1;
        free_idx = IdxW'(i);
      end
    end
  end

  always_comb begin
    top_nxt = '0;
    for (int i = 0; i < Slots; i++) begin
      if (live_r[i]) top_nxt = CntW'(i + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) req_r <= in_data;
    if (cmd.read) begin
      rd_inst_r <= mem_inst[idx];
      rd_own_r <= mem_own[idx];
      rd_obj_r <= mem_obj[idx];
    end
    if (cmd.scan) begin
      rd_inst_r <= mem_inst[scan_r];
      rd_obj_r <= mem_obj[scan_r];
    end
    if (cmd.exec && req_r.opcode == OP_ADD && (free_found || 32'(hw_r) < Slots)) begin
      mem_inst[free_found ? free_idx : hw_r[IdxW-1:0]] <= inst_use;
      mem_own[free_found ? free_idx : hw_r[IdxW-1:0]] <= req_r.owner_id;
      mem_obj[free_found ? free_idx : hw_r[IdxW-1:0]] <= req_r.object_id;
    end
  end

  logic [IdxW-1:0] scan_prev_r;
  logic scan_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= '0;
      hw_r <= '0;
      next_inst_r <= 14'd1;
      count_r <= '0;
      scan_done_r <= 1'b0;
      need_hwm_r <= 1'b0;
      hwm_done_r <= 1'b0;
      scan_vld_r <= 1'b0;
      scan_r <= '0;
    end else begin
      if (cmd.load) begin
        st_r <= ST_BAD;
        hout_r <= '0;
        oout_r <= '0;
        scan_r <= '0;
        scan_vld_r <= 1'b0;
        scan_done_r <= 1'b0;
        need_hwm_r <= 1'b0;
        hwm_done_r <= 1'b0;
      end
      if (cmd.exec) begin
        unique case (req_r.opcode)
          OP_ADD: begin
            if (free_found || 32'(hw_r) < Slots) begin
              live_r[free_found ? free_idx : hw_r[IdxW-1:0]] <= 1'b1;
              if (!free_found) hw_r <= hw_r + 1'b1;
              next_inst_r <= inst_use + 14'd1;
              count_r <= count_r + 16'd1;
              hout_r <= {inst_use, 1'b0,
                         15'(free_found ? free_idx : hw_r[IdxW-1:0])};
              st_r <= ST_OK;
            end else begin
              st_r <= ST_FULL;
            end
          end
          OP_REMOVE: begin
            if (hv) begin
              live_r[idx] <= 1'b0;
              count_r <= count_r - 16'd1;
              need_hwm_r <= (32'(h_idx) + 1 == 32'(hw_r));
              st_r <= ST_OK;
            end
          end
          OP_LOOKUP, OP_LOOKUP_OWN: begin
            if (hv && (req_r.opcode == OP_LOOKUP || rd_own_r == req_r.owner_id)) begin
              oout_r <= rd_obj_r;
              st_r <= ST_OK;
            end
          end
          OP_FIND: st_r <= ST_NOT_FOUND;
          default: st_r <= ST_BAD;
        endcase
      end
      if (cmd.scan && !scan_done_r) begin
        if (scan_vld_r && live_r[scan_prev_r] && rd_obj_r == req_r.object_id
            && (CntW'(scan_prev_r) < hw_r)) begin
          hout_r <= {rd_inst_r, 1'b0, 15'(scan_prev_r)};
          st_r <= ST_OK;
          scan_done_r <= 1'b1;
        end else if ((scan_vld_r && 32'(scan_prev_r) == Slots - 1)
                     || (CntW'(scan_r) >= hw_r && !(scan_vld_r && scan_r == '0))) begin
          scan_done_r <= 1'b1;
        end else if (hw_r == '0) begin
          scan_done_r <= 1'b1;
        end
        scan_prev_r <= scan_r;
        scan_vld_r <= 1'b1;
        if (32'(scan_r) != Slots - 1) scan_r <= scan_r + 1'b1;
      end
      if (cmd.hwm) begin
        hw_r <= top_nxt;
        hwm_done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result_r.status <= st_r;
      result_r.handle_out <= hout_r;
      result_r.object_out <= oout_r;
      result_r.live_entries <= count_r;
    end
  end

  assign result = result_r;
  assign stat.need_scan = (req_r.opcode == OP_FIND);
  assign stat.scan_done = scan_done_r;
  assign stat.need_hwm = need_hwm_r;
  assign stat.hwm_done = hwm_done_r;
endmodule

// ----- hdl/ght_ctrl.sv -----
// Controller state machine sequencing one transaction at a time.
// Depends on ght_pkg.
module ght_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  ght_pkg::ght_stat_t stat,
  output ght_pkg::ght_cmd_t cmd
);
  import ght_pkg::*;

  ght_state_t state_r, state_nxt;
  logic ov_r, ov_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_READ;
      S_READ: state_nxt = S_EXEC;
      S_EXEC: state_nxt = stat.need_scan ? S_SCAN : S_HWM;
      S_SCAN: if (stat.scan_done) state_nxt = S_DONE;
      S_HWM: state_nxt = S_DONE;
      S_DONE: if (!ov_r || !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: cmd.load = in_valid;
      S_READ: cmd.read = 1'b1;
      S_EXEC: cmd.exec = 1'b1;
      S_SCAN: cmd.scan = 1'b1;
      S_HWM: cmd.hwm = stat.need_hwm;
      S_DONE: cmd.out_load = !ov_r || !out_stall;
      default: cmd = '0;
    endcase
    ov_nxt = cmd.out_load ? 1'b1 : (ov_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
    end
  end

  assign out_valid = ov_r;
endmodule

// ----- hdl/generational_handle_table.sv -----
// Generational handle table of 256 slots: add, remove, lookup, owner lookup
// and find handle. One transaction at a time: every operation passes the read
// and execute states; add, remove and lookup then pass the high-water state,
// while find handle walks the slot memory one entry a cycle in the scan state.
// The result register holds a finished result while the next transaction is
// accepted.
// Depends on ght_pkg, ght_ctrl, ght_datapath and the assertion header.
module generational_handle_table (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  ght_pkg::ght_in_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output ght_pkg::ght_out_t out_data
);
  import ght_pkg::*;
  `include "generational_handle_table_assert.svh"

  ght_cmd_t cmd;
  ght_stat_t stat;

  ght_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .stat(stat), .cmd(cmd)
  );

  ght_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .cmd(cmd), .stat(stat),
    .result(out_data)
  );

  `GHT_ASSERT_IMP(a_cmd_onehot, clk, rst_n, 1'b1, $onehot0(cmd), "commands overlap")
  `GHT_ASSERT_NEXT(a_load_read, clk, rst_n, cmd.load, cmd.read, "read missing after load")
  `GHT_ASSERT_IMP(a_no_load_busy, clk, rst_n, in_stall, !cmd.load, "load while busy")
endmodule

// ----- bench/tb.sv -----
// Self-checking bench for generational_handle_table: directed and random
// handle operations checked against an in-bench table model.
// Depends on ght_pkg and the generational_handle_table RTL.
`timescale 1ns / 100ps

module tb;
  import ght_pkg::*;

  localparam int WatchdogLimit = 20000;
  localparam int DrainCycles = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  ght_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ght_out_t out_data;

  // table model state
  logic        tbl_live [Slots];
  logic [13:0] tbl_inst [Slots];
  logic [13:0] tbl_owner [Slots];
  logic [15:0] tbl_obj [Slots];
  int unsigned tbl_hwm;
  logic [13:0] tbl_next_inst;
  logic [15:0] tbl_count;

  ght_out_t expected_q[$];
  logic [29:0] issued_handles[$];
  int errors = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  int recv_left = 0;
  bit send_gaps = 1'b1;
  bit recv_gaps = 1'b1;
  bit hold_recv = 1'b0;

  always #2 clk = ~clk;

  generational_handle_table DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  function automatic bit handle_ok(input logic [29:0] h, output int idx);
    idx = int'(h[14:0]);
    if (idx >= tbl_hwm || idx >= Slots) return 1'b0;
    if (!tbl_live[idx]) return 1'b0;
    return tbl_inst[idx] == h[29:16];
  endfunction

  function automatic ght_out_t table_apply(input ght_in_t t);
    ght_out_t r;
    int i;
    int top;
    r = '0;
    r.status = ST_BAD;
    case (t.opcode)
      OP_ADD: begin
        for (i = 0; i < tbl_hwm; i++) if (!tbl_live[i]) break;
        if (i == tbl_hwm && tbl_hwm >= Slots) begin
          r.status = ST_FULL;
        end else begin
          if (tbl_next_inst == 14'd0) tbl_next_inst = 14'd1;
          tbl_live[i] = 1'b1;
          tbl_inst[i] = tbl_next_inst;
          tbl_owner[i] = t.owner_id;
          tbl_obj[i] = t.object_id;
          r.handle_out = {tbl_next_inst, 1'b0, 15'(i)};
          tbl_next_inst = tbl_next_inst + 14'd1;
          if (i == tbl_hwm) tbl_hwm++;
          tbl_count = tbl_count + 16'd1;
          r.status = ST_OK;
        end
      end
      OP_REMOVE: begin
        if (handle_ok(t.handle, i)) begin
          tbl_live[i] = 1'b0;
          tbl_count = tbl_count - 16'd1;
          if (i + 1 == tbl_hwm) begin
            top = i;
            while (top > 0 && !tbl_live[top-1]) top--;
            tbl_hwm = top;
          end
          r.status = ST_OK;
        end
      end
      OP_LOOKUP, OP_LOOKUP_OWN: begin
        if (handle_ok(t.handle, i) &&
            (t.opcode == OP_LOOKUP || tbl_owner[i] == t.owner_id)) begin
          r.object_out = tbl_obj[i];
          r.status = ST_OK;
        end
      end
      OP_FIND: begin
        r.status = ST_NOT_FOUND;
        for (i = 0; i < tbl_hwm; i++)
          if (tbl_live[i] && tbl_obj[i] == t.object_id) begin
            r.handle_out = {tbl_inst[i], 1'b0, 15'(i)};
            r.status = ST_OK;
            break;
          end
      end
      default: ;
    endcase
    r.live_entries = tbl_count;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
  endtask

  task automatic send_op(input ght_in_t t);
    ght_out_t r;
    int gap;
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = table_apply(t);
    expected_q.push_back(r);
    if (t.opcode == OP_ADD && r.status == ST_OK) begin
      issued_handles.push_back(r.handle_out);
      if (issued_handles.size() > 64) void'(issued_handles.pop_front());
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic ght_in_t make_op(input logic [2:0] op, input logic [15:0] obj,
                                      input logic [13:0] own, input logic [29:0] h);
    ght_in_t t;
    t.opcode = op; t.object_id = obj; t.owner_id = own; t.handle = h;
    return t;
  endfunction

  function automatic logic [29:0] pick_handle();
    logic [29:0] h;
    int k;
    if (issued_handles.size() != 0 && $urandom_range(0, 9) < 8) begin
      h = issued_handles[$urandom_range(0, issued_handles.size() - 1)];
      k = $urandom_range(0, 9);
      if (k == 0) h[15] = ~h[15];
      else if (k == 1) h[29:16] = 14'($urandom);
      return h;
    end
    h = 30'($urandom);
    if ($urandom_range(0, 1)) h[14:0] = 15'($urandom_range(0, Slots + 3));
    return h;
  endfunction

  function automatic ght_in_t random_op();
    logic [2:0] op;
    logic [15:0] obj;
    int k;
    k = $urandom_range(0, 99);
    if (k < 30) op = OP_ADD;
    else if (k < 55) op = OP_REMOVE;
    else if (k < 70) op = OP_LOOKUP;
    else if (k < 82) op = OP_LOOKUP_OWN;
    else if (k < 97) op = OP_FIND;
    else op = 3'($urandom_range(5, 7));
    obj = $urandom_range(0, 3) == 0 ? 16'($urandom_range(1, 65535))
                                    : 16'($urandom_range(1, 24));
    if ($urandom_range(0, 40) == 0) obj = 16'hffff;
    return make_op(op, obj, $urandom_range(0, 3) == 0 ? 14'($urandom) :
                   14'($urandom_range(0, 3)), pick_handle());
  endfunction

  task automatic test_directed();
    logic [29:0] h0;
    logic [29:0] h1;
    send_op(make_op(OP_FIND, 16'd1, 14'd0, 30'd0));
    send_op(make_op(OP_REMOVE, 16'd0, 14'd0, 30'd0));
    send_op(make_op(OP_ADD, 16'd1, 14'd0, 30'd0));
    h0 = expected_q[$].handle_out;
    send_op(make_op(OP_ADD, 16'hffff, 14'h3fff, 30'h3fffffff));
    h1 = expected_q[$].handle_out;
    send_op(make_op(OP_LOOKUP, 16'd0, 14'd0, h0));
    send_op(make_op(OP_LOOKUP_OWN, 16'd0, 14'h3fff, h1));
    send_op(make_op(OP_LOOKUP_OWN, 16'd0, 14'd1, h1));
    send_op(make_op(OP_LOOKUP, 16'd0, 14'd0, h0 | 30'h8000));
    send_op(make_op(OP_LOOKUP, 16'd0, 14'd0, {14'd0, 16'd0}));
    send_op(make_op(OP_FIND, 16'hffff, 14'd0, 30'd0));
    send_op(make_op(OP_REMOVE, 16'd0, 14'd0, h0));
    send_op(make_op(OP_REMOVE, 16'd0, 14'd0, h0));
    send_op(make_op(OP_ADD, 16'd7, 14'd2, 30'd0));
    send_op(make_op(OP_REMOVE, 16'd0, 14'd0, h1));
    send_op(make_op(OP_REMOVE, 16'd0, 14'd0, 30'h3fff7fff));
    for (int op = 5; op < 8; op++) send_op(make_op(3'(op), 16'd1, 14'd0, h0));
    send_op(make_op(OP_FIND, 16'd9, 14'd0, 30'd0));
  endtask

  // fill to full, probe past the top, empty, then refill a few and empty again
  task automatic test_fill_and_wrap();
    for (int i = 0; i < Slots + 2; i++)
      send_op(make_op(OP_ADD, 16'(i + 1), 14'(i), 30'd0));
    send_op(make_op(OP_FIND, 16'(Slots), 14'd0, 30'd0));
    send_op(make_op(OP_LOOKUP, 16'd0, 14'd0, 30'h00010000 | 30'(Slots)));
    for (int i = Slots - 1; i >= 0; i--)
      send_op(make_op(OP_REMOVE, 16'd0, 14'd0, {tbl_inst[i], 16'(i)}));
    send_op(make_op(OP_ADD, 16'd3, 14'd3, 30'd0));
    repeat (4) send_op(make_op(OP_ADD, 16'd4, 14'd4, 30'd0));
    for (int i = 0; i < tbl_hwm; i++)
      if (tbl_live[i]) send_op(make_op(OP_REMOVE, 16'd0, 14'd0, {tbl_inst[i], 16'(i)}));
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_recv = 1'b1;
        repeat (200) @(posedge clk);
        hold_recv = 1'b0;
      end
      repeat (20) send_op(random_op());
    join
    wait_drained();
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) wait_drained();
      if (i == n - 150) begin
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
      end
      send_op(random_op());
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n || hold_recv) begin
      out_stall <= hold_recv;
      recv_left <= 0;
    end else if (recv_left > 0) begin
      out_stall <= 1'b1;
      recv_left <= recv_left - 1;
    end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      recv_left <= $urandom_range(0, 9);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    ght_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", 32'(out_data.status), 32'd0);
      end else begin
        want = expected_q.pop_front();
        if (out_data.status !== want.status)
          report_mismatch("status", 32'(out_data.status), 32'(want.status));
        if (out_data.handle_out !== want.handle_out)
          report_mismatch("handle_out", 32'(out_data.handle_out), 32'(want.handle_out));
        if (out_data.object_out !== want.object_out)
          report_mismatch("object_out", 32'(out_data.object_out), 32'(want.object_out));
        if (out_data.live_entries !== want.live_entries)
          report_mismatch("live_entries", 32'(out_data.live_entries),
                          32'(want.live_entries));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < Slots; i++) begin
      tbl_live[i] = 1'b0; tbl_inst[i] = '0; tbl_owner[i] = '0; tbl_obj[i] = '0;
    end
    tbl_hwm = 0;
    tbl_next_inst = 14'd1;
    tbl_count = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_fill_and_wrap();
    test_backpressure();
    test_random(640);
    wait_drained();
    $display("Covered directed edge cases, table fill/empty, bad handles,");
    $display("backpressure and %0d checked results.", results_seen);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule
